>>> rtl/sust_pkg.sv
// Shared types and constants for the sorted unique set table.
// Used by the controller, the datapath and the top level; depends on nothing.
package sust_pkg;

    localparam int CAPACITY  = 16;
    localparam int KEY_WIDTH = 32;

    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMD_W    = 2;
    localparam int KEY_IN_W = 32;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 3;
    localparam int FIELD_W  = 5;
    localparam int POSX_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef logic [KEY_WIDTH-1:0] t_key;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [ADDR_W-1:0]    t_addr;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_ERASE  = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_command;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FULL     = 3'd3,
        ST_BADPOS   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_SHIFT,
        S_PUT,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_run;
        logic shift_start;
        logic shift_run;
        logic put;
        logic finish;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_command command;
        logic     pos_bad;
        logic     scan_hit;
        logic     scan_end;
        logic     shift_end;
        logic     full;
        logic     out_free;
    } t_dp_sts;

endpackage

>>> rtl/sust_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module sust_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/sust_ctrl.sv
// Sequencing state machine for the sorted unique set table.
// Depends on sust_pkg; drives datapath commands from datapath status.
module sust_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  sust_pkg::t_dp_sts i_sts,
    output sust_pkg::t_dp_cmd o_cmd
);

    sust_pkg::t_state r_state;
    sust_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sust_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sust_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = sust_pkg::S_DECIDE;
                end
            end
            sust_pkg::S_DECIDE: begin
                unique case (i_sts.command) inside
                    sust_pkg::CMD_INSERT, sust_pkg::CMD_FIND: begin
                        n_state = sust_pkg::S_SCAN;
                    end
                    sust_pkg::CMD_ERASE: begin
                        n_state = i_sts.pos_bad ? sust_pkg::S_DONE : sust_pkg::S_SHIFT;
                    end
                    sust_pkg::CMD_CLEAR: begin
                        n_state = sust_pkg::S_DONE;
                    end
                endcase
            end
            sust_pkg::S_SCAN: begin
                if (i_sts.scan_hit || i_sts.scan_end) begin
                    if (i_sts.command == sust_pkg::CMD_INSERT && !i_sts.scan_hit
                        && !i_sts.full) begin
                        n_state = sust_pkg::S_SHIFT;
                    end else begin
                        n_state = sust_pkg::S_DONE;
                    end
                end
            end
            sust_pkg::S_SHIFT: begin
                if (i_sts.shift_end) begin
                    n_state = (i_sts.command == sust_pkg::CMD_INSERT) ?
                              sust_pkg::S_PUT : sust_pkg::S_DONE;
                end
            end
            sust_pkg::S_PUT: begin
                n_state = sust_pkg::S_DONE;
            end
            sust_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = sust_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sust_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != sust_pkg::S_IDLE);
        unique case (r_state)
            sust_pkg::S_IDLE: begin
                o_cmd.load = i_in_valid;
            end
            sust_pkg::S_DECIDE: begin
                o_cmd.scan_start  = (i_sts.command == sust_pkg::CMD_INSERT) ||
                                    (i_sts.command == sust_pkg::CMD_FIND);
                o_cmd.shift_start = (i_sts.command == sust_pkg::CMD_ERASE) && !i_sts.pos_bad;
            end
            sust_pkg::S_SCAN: begin
                o_cmd.scan_run    = 1'b1;
                o_cmd.shift_start = (i_sts.scan_hit || i_sts.scan_end) &&
                                    i_sts.command == sust_pkg::CMD_INSERT &&
                                    !i_sts.scan_hit && !i_sts.full;
            end
            sust_pkg::S_SHIFT: begin
                o_cmd.shift_run = 1'b1;
            end
            sust_pkg::S_PUT: begin
                o_cmd.put = 1'b1;
            end
            sust_pkg::S_DONE: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/sust_dp.sv
// Datapath for the sorted unique set table: item registers, scan and shift
// pointers, count, result register. Depends on sust_pkg; drives the key RAM.
module sust_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sust_pkg::t_dp_cmd                   i_cmd,
    output sust_pkg::t_dp_sts                   o_sts,
    input  logic [sust_pkg::CMD_W-1:0]          i_command,
    input  logic signed [sust_pkg::KEY_IN_W-1:0] i_key,
    input  logic [sust_pkg::POS_W-1:0]          i_position,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [sust_pkg::STATUS_W-1:0]       o_status,
    output logic [sust_pkg::FIELD_W-1:0]        o_found_position,
    output logic [sust_pkg::FIELD_W-1:0]        o_count,
    output logic                                o_ram_we,
    output sust_pkg::t_addr                     o_ram_waddr,
    output sust_pkg::t_key                      o_ram_wdata,
    output logic                                o_ram_re,
    output sust_pkg::t_addr                     o_ram_raddr,
    input  sust_pkg::t_key                      i_ram_rdata
);

    sust_pkg::t_cnt     r_count;
    sust_pkg::t_command r_cmd;
    sust_pkg::t_key     r_key;
    logic [sust_pkg::POS_W-1:0] r_pos;
    sust_pkg::t_cnt     r_idx;
    logic               r_rd_pend;
    sust_pkg::t_cnt     r_rd_idx;
    sust_pkg::t_cnt     r_at;
    logic               r_at_set;
    logic               r_hit;
    sust_pkg::t_cnt     r_hit_idx;
    logic               r_wr_pend;
    sust_pkg::t_addr    r_wr_addr;
    logic               r_out_valid;
    logic [sust_pkg::STATUS_W-1:0] r_out_status;
    logic [sust_pkg::FIELD_W-1:0]  r_out_fpos;
    logic [sust_pkg::FIELD_W-1:0]  r_out_count;

    logic [sust_pkg::POSX_W-1:0] w_pos_ext;
    logic [sust_pkg::POSX_W-1:0] w_cnt_ext;
    logic               w_pos_bad;
    logic               w_is_ins;
    logic               w_scan_rd;
    logic               w_shift_rd;
    logic               w_key_eq;
    logic               w_key_gt;
    logic               w_full;
    logic               w_out_free;
    sust_pkg::t_cnt     w_at_final;
    sust_pkg::t_cnt     w_idx_m1;
    sust_pkg::t_cnt     w_dest;
    sust_pkg::t_status  n_status;
    sust_pkg::t_cnt     n_fpos;
    sust_pkg::t_cnt     n_count;

    assign w_pos_ext  = sust_pkg::POSX_W'(r_pos);
    assign w_cnt_ext  = sust_pkg::POSX_W'(r_count);
    assign w_pos_bad  = (w_pos_ext >= w_cnt_ext);
    assign w_is_ins   = (r_cmd == sust_pkg::CMD_INSERT);
    assign w_scan_rd  = (r_idx < r_count);
    assign w_shift_rd = w_is_ins ? (r_idx > r_at) : (r_idx < r_count);
    assign w_key_eq   = (i_ram_rdata == r_key);
    assign w_key_gt   = ($signed(i_ram_rdata) > $signed(r_key));
    assign w_full     = (r_count >= sust_pkg::t_cnt'(sust_pkg::CAPACITY));
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_at_final = r_at_set ? r_at : r_count;
    assign w_idx_m1   = r_idx - sust_pkg::t_cnt'(1);
    // Insert moves entries up one slot, erase moves them down one slot
    assign w_dest     = w_is_ins ? r_idx : w_idx_m1;

    // Key RAM ports
    assign o_ram_re    = (i_cmd.scan_run && w_scan_rd) || (i_cmd.shift_run && w_shift_rd);
    assign o_ram_raddr = (i_cmd.scan_run || !w_is_ins) ? r_idx[sust_pkg::ADDR_W-1:0]
                                                       : w_idx_m1[sust_pkg::ADDR_W-1:0];
    assign o_ram_we    = r_wr_pend || i_cmd.put;
    assign o_ram_waddr = i_cmd.put ? r_at[sust_pkg::ADDR_W-1:0] : r_wr_addr;
    assign o_ram_wdata = i_cmd.put ? r_key : i_ram_rdata;

    // Result of the finished item
    always_comb begin
        n_status = sust_pkg::ST_OK;
        n_fpos   = '0;
        n_count  = r_count;
        unique case (r_cmd)
            sust_pkg::CMD_INSERT: begin
                if (r_hit) begin
                    n_status = sust_pkg::ST_DUP;
                end else if (w_full) begin
                    n_status = sust_pkg::ST_FULL;
                end else begin
                    n_count = r_count + sust_pkg::t_cnt'(1);
                end
            end
            sust_pkg::CMD_FIND: begin
                if (r_hit) begin
                    n_fpos = r_hit_idx;
                end else begin
                    n_status = sust_pkg::ST_NOTFOUND;
                    n_fpos   = r_count;
                end
            end
            sust_pkg::CMD_ERASE: begin
                if (w_pos_bad) begin
                    n_status = sust_pkg::ST_BADPOS;
                end else begin
                    n_count = r_count - sust_pkg::t_cnt'(1);
                end
            end
            sust_pkg::CMD_CLEAR: begin
                n_count = '0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rd_pend   <= 1'b0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.scan_start || i_cmd.shift_start) begin
                r_rd_pend <= 1'b0;
                r_wr_pend <= 1'b0;
            end else begin
                if (i_cmd.scan_run) begin
                    r_rd_pend <= w_scan_rd;
                end
                if (i_cmd.shift_run) begin
                    r_wr_pend <= w_shift_rd;
                end
            end
            if (i_cmd.finish) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= sust_pkg::t_command'(i_command);
            r_key <= sust_pkg::t_key'($unsigned(i_key));
            r_pos <= i_position;
        end
        if (i_cmd.scan_start) begin
            r_idx    <= '0;
            r_hit    <= 1'b0;
            r_at_set <= 1'b0;
        end else if (i_cmd.shift_start) begin
            if (w_is_ins) begin
                r_idx <= r_count;
                r_at  <= w_at_final;
            end else begin
                r_idx <= sust_pkg::t_cnt'(w_pos_ext + sust_pkg::POSX_W'(1));
            end
        end else if (i_cmd.scan_run) begin
            if (w_scan_rd) begin
                r_idx <= r_idx + sust_pkg::t_cnt'(1);
            end
            r_rd_idx <= r_idx;
            if (r_rd_pend) begin
                if (w_key_eq) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_rd_idx;
                end else if (!r_at_set && w_key_gt) begin
                    r_at_set <= 1'b1;
                    r_at     <= r_rd_idx;
                end
            end
        end else if (i_cmd.shift_run) begin
            if (w_shift_rd) begin
                r_idx     <= w_is_ins ? w_idx_m1 : r_idx + sust_pkg::t_cnt'(1);
                r_wr_addr <= w_dest[sust_pkg::ADDR_W-1:0];
            end
        end
        if (i_cmd.finish) begin
            r_out_status <= n_status;
            r_out_fpos   <= sust_pkg::FIELD_W'(n_fpos);
            r_out_count  <= sust_pkg::FIELD_W'(n_count);
        end
    end

    assign o_sts.command   = r_cmd;
    assign o_sts.pos_bad   = w_pos_bad;
    assign o_sts.scan_hit  = r_rd_pend && w_key_eq;
    assign o_sts.scan_end  = !r_rd_pend && !w_scan_rd;
    assign o_sts.shift_end = !w_shift_rd && !r_wr_pend;
    assign o_sts.full      = w_full;
    assign o_sts.out_free  = w_out_free;

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_found_position = r_out_fpos;
    assign o_count          = r_out_count;

endmodule

>>> rtl/sorted_unique_set_table.sv
// Sorted unique set table: top level joining controller, datapath and key RAM.
// Depends on sust_pkg, sust_ram, sust_ctrl and sust_dp.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request item: a
//   command (insert, find, erase at position, clear), a signed key and an
//   erase position. Output channel (o_out_valid / i_out_stall) returns one
//   result item per request: status, found position and the count after it.
//   An item moves on an edge where valid is high and stall is low.
//   Keys live in a single-port-read RAM, kept ascending, no duplicates.
//   One item is worked at a time. A find or an insert scans the entries until
//   a hit or the count; an insert then shifts the entries from its slot up
//   and writes the key, an erase shifts the entries above the position down.
//   The RAM read port sets the pace: one entry is compared or moved per cycle.
//   With 15 entries an insert below every key is the slowest item.
//   Reset clears the entry count and all handshake state; the key RAM is not
//   cleared, since only entries below the count are ever read.
//   While the receiver stalls, the result holds in the output register; the
//   next item is still accepted and worked, and waits to load its result
//   until the held one has been taken.
module sorted_unique_set_table (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [sust_pkg::CMD_W-1:0]           i_command,
    input  logic signed [sust_pkg::KEY_IN_W-1:0] i_key,
    input  logic [sust_pkg::POS_W-1:0]           i_position,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [sust_pkg::STATUS_W-1:0]        o_status,
    output logic [sust_pkg::FIELD_W-1:0]         o_found_position,
    output logic [sust_pkg::FIELD_W-1:0]         o_count
);

    sust_pkg::t_dp_cmd w_cmd;
    sust_pkg::t_dp_sts w_sts;

    logic            w_ram_we;
    sust_pkg::t_addr w_ram_waddr;
    sust_pkg::t_key  w_ram_wdata;
    logic            w_ram_re;
    sust_pkg::t_addr w_ram_raddr;
    sust_pkg::t_key  w_ram_rdata;

    // Sequencer: dispatch, scan, shift, key write, result hand-off
    sust_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Pointers, count and result register
    sust_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_command        (i_command),
        .i_key            (i_key),
        .i_position       (i_position),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_count          (o_count),
        .o_ram_we         (w_ram_we),
        .o_ram_waddr      (w_ram_waddr),
        .o_ram_wdata      (w_ram_wdata),
        .o_ram_re         (w_ram_re),
        .o_ram_raddr      (w_ram_raddr),
        .i_ram_rdata      (w_ram_rdata)
    );

    // Key store, ascending order in slots 0 .. count-1
    sust_ram #(
        .WIDTH (sust_pkg::KEY_WIDTH),
        .DEPTH (sust_pkg::CAPACITY)
    ) u_keys (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // The table is only written while an item is in work
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> o_in_stall)
        else $error("key RAM written while idle");

    // Finishing an item loads a result and frees the input side
    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |=> (o_out_valid && !o_in_stall))
        else $error("finish did not present a result");

    // An accepted item holds off the next one
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("accepted item did not start work");

    // A missed find reports the count as its position
    a_notfound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == sust_pkg::ST_NOTFOUND) |-> (o_found_position == o_count))
        else $error("not-found position differs from count");

endmodule
